// ----- hw/rtl/great_circle_distance_defines.svh -----
// Assertion macros shared by the great-circle distance RTL.
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// Check that cons holds in every cycle in which ante holds.
`define GCD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd: implication check failed");

// Check that cond never holds.
`define GCD_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gcd: forbidden condition seen");

`endif

// ----- hw/rtl/gcd_pkg.sv -----
// Shared constants and the arctangent table for the great-circle distance pipeline.
package gcd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CORDIC_XW = 36;
  localparam int CORDIC_ZW = 34;
  localparam int QW = 34;
  localparam int ISQRT_STEPS = 32;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // 3600000000 = 2^10 * 3515625
  localparam logic [21:0] ANG_DIV = 22'd3515625;
  localparam logic [63:0] ANG_RECIP_W = (64'd1 << 53) / 64'd3515625;
  localparam logic [31:0] ANG_RECIP = ANG_RECIP_W[31:0];

  localparam logic [32:0] DIST_SCALE = 33'd6404827775;
  localparam logic [27:0] DIST_MAX = 28'd200150867;

  function automatic logic [29:0] atan_lut(input int idx);
    logic [29:0] v;
    case (idx)
      0: v = 30'd536870912;
      1: v = 30'd316933406;
      2: v = 30'd167458907;
      3: v = 30'd85004756;
      4: v = 30'd42667331;
      5: v = 30'd21354465;
      6: v = 30'd10679838;
      7: v = 30'd5340245;
      8: v = 30'd2670163;
      9: v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/great_circle_distance.sv -----
// Top level: great-circle distance between two coordinate pairs, fully pipelined.
// Throughput: one item per clock; busy is always low and results cannot be held off.
// Depth is set by two CORDIC chains and the 32-step square-root chain.
// Reset (synchronous, rst_n low) clears all valid bits; data registers are not reset.
`include "great_circle_distance_defines.svh"

module great_circle_distance #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_current_lat,
  input  logic signed [31:0] in_current_lon,
  input  logic signed [30:0] in_target_lat,
  input  logic signed [31:0] in_target_lon,
  output logic               out_valid,
  output logic [27:0]        out_distance_dm
);

  localparam int XW = gcd_pkg::CORDIC_XW;
  localparam int ZW = gcd_pkg::CORDIC_ZW;
  localparam int QW = gcd_pkg::QW;

  localparam logic signed [32:0] QUARTER_S = 33'(gcd_pkg::QUARTER_TURN);
  localparam logic signed [32:0] HALF_S    = 33'(gcd_pkg::HALF_TURN);

  // Q30 product with floor shift
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[QW+29:30];
  endfunction

  // Every stage takes an item each cycle, so the block never pushes back.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stages 1-3: degrees*1e7 to binary angle, trunc(v * 2^22 / 3515625).
  // Magnitude times a 32-bit reciprocal gives a quotient low by at most one;
  // the remainder check then fixes it up, and the sign is put back.
  // ---------------------------------------------------------------------------
  logic signed [31:0] coord [4];
  assign coord[0] = 32'(in_current_lat);
  assign coord[1] = in_current_lon;
  assign coord[2] = 32'(in_target_lat);
  assign coord[3] = in_target_lon;

  logic        v1_r, v2_r, v3_r;
  logic        neg1_nxt [4], neg1_r [4], neg2_r [4];
  logic [31:0] mag1_nxt [4], mag1_r [4], mag2_r [4];
  logic [63:0] prod1_nxt[4], prod1_r[4];
  logic [31:0] q0_nxt   [4], q0_r   [4];
  logic [53:0] prod2_nxt[4], prod2_r[4];
  logic [31:0] ang3_nxt [4], ang3_r [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [31:0] cu;
      logic [53:0] rem;
      logic [31:0] qc;
      cu           = coord[k];
      neg1_nxt[k]  = cu[31];
      mag1_nxt[k]  = cu[31] ? (32'd0 - cu) : cu;
      prod1_nxt[k] = {32'd0, mag1_nxt[k]} * {32'd0, gcd_pkg::ANG_RECIP};
      q0_nxt[k]    = prod1_r[k][62:31];
      prod2_nxt[k] = 54'(q0_nxt[k]) * 54'(gcd_pkg::ANG_DIV);
      rem          = {mag2_r[k], 22'd0} - prod2_r[k];
      qc           = q0_r[k] + 32'(rem >= 54'(gcd_pkg::ANG_DIV));
      ang3_nxt[k]  = neg2_r[k] ? (32'd0 - qc) : qc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      neg1_r[k]  <= neg1_nxt[k];
      mag1_r[k]  <= mag1_nxt[k];
      prod1_r[k] <= prod1_nxt[k];
      neg2_r[k]  <= neg1_r[k];
      mag2_r[k]  <= mag1_r[k];
      q0_r[k]    <= q0_nxt[k];
      prod2_r[k] <= prod2_nxt[k];
      ang3_r[k]  <= ang3_nxt[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: wrap the longitude difference and fold each angle into
  // [-quarter, +quarter]; a folded lane has its sine and cosine negated later.
  // Lanes: 0 current latitude, 1 target latitude, 2 longitude difference.
  // ---------------------------------------------------------------------------
  logic                 v4_r;
  logic signed [ZW-1:0] rot_z_nxt[3], rot_z_r[3];
  logic [2:0]           rot_neg_nxt, rot_neg_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [31:0] z32;
      logic signed [32:0] z33;
      if (j == 0) begin
        z32 = ang3_r[0];
      end else if (j == 1) begin
        z32 = ang3_r[2];
      end else begin
        z32 = ang3_r[3] - ang3_r[1];
      end
      z33 = 33'(z32);
      if (z33 > QUARTER_S) begin
        rot_neg_nxt[j] = 1'b1;
        z33            = z33 - HALF_S;
      end else if (z33 < -QUARTER_S) begin
        rot_neg_nxt[j] = 1'b1;
        z33            = z33 + HALF_S;
      end else begin
        rot_neg_nxt[j] = 1'b0;
      end
      rot_z_nxt[j] = ZW'(z33);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    rot_z_r   <= rot_z_nxt;
    rot_neg_r <= rot_neg_nxt;
  end

  // Rotation CORDIC lanes: cos in x, sin in y.
  logic                 rot_vld[3];
  logic signed [XW-1:0] rot_x[3], rot_y[3];

  for (genvar j = 0; j < 3; j++) begin : g_rot
    gcd_cordic #(
      .STAGES   (CORDIC_STAGES),
      .VECTORING(1'b0)
    ) u_rot (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v4_r),
      .in_x     (XW'(gcd_pkg::CORDIC_GAIN)),
      .in_y     ('0),
      .in_z     (rot_z_r[j]),
      .out_valid(rot_vld[j]),
      .out_x    (rot_x[j]),
      .out_y    (rot_y[j]),
      .out_z    ()
    );
  end

  // Hold the fold flags alongside the CORDIC chain.
  logic [2:0] negd_r[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    negd_r[0] <= rot_neg_r;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      negd_r[i] <= negd_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: undo the fold.
  // ---------------------------------------------------------------------------
  logic                 v5_r;
  logic signed [QW-1:0] sin_nxt[3], cos_nxt[3], sin_r[3], cos_r[3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [XW-1:0] xs, ys;
      xs         = negd_r[CORDIC_STAGES-1][j] ? -rot_x[j] : rot_x[j];
      ys         = negd_r[CORDIC_STAGES-1][j] ? -rot_y[j] : rot_y[j];
      cos_nxt[j] = xs[QW-1:0];
      sin_nxt[j] = ys[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= rot_vld[0] && rot_vld[1] && rot_vld[2];
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stages 6-8: spherical terms
  //   b = ct*sd, a = cc*st - (sc*ct)*cd, c = sc*st + (cc*ct)*cd
  // ---------------------------------------------------------------------------
  logic                 v6_r, v7_r, v8_r;
  logic signed [QW-1:0] b6_r, p1_r, p3_r, t1_r, t2_r, cd6_r;
  logic signed [QW-1:0] b7_r, p1_7_r, p3_7_r, u1_r, u2_r;
  logic signed [QW-1:0] a8_nxt, c8_nxt, a8_r, b8_r, c8_r;

  assign a8_nxt = p1_7_r - u1_r;
  assign c8_nxt = p3_7_r + u2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    b6_r   <= mulq(cos_r[1], sin_r[2]);
    p1_r   <= mulq(cos_r[0], sin_r[1]);
    p3_r   <= mulq(sin_r[0], sin_r[1]);
    t1_r   <= mulq(sin_r[0], cos_r[1]);
    t2_r   <= mulq(cos_r[0], cos_r[1]);
    cd6_r  <= cos_r[2];
    b7_r   <= b6_r;
    p1_7_r <= p1_r;
    p3_7_r <= p3_r;
    u1_r   <= mulq(t1_r, cd6_r);
    u2_r   <= mulq(t2_r, cd6_r);
    a8_r   <= a8_nxt;
    b8_r   <= b7_r;
    c8_r   <= c8_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stages 9-10: a^2 + b^2 in Q60.
  // ---------------------------------------------------------------------------
  logic                   v9_r, v10_r;
  logic signed [2*QW-1:0] sqa_nxt, sqb_nxt;
  logic [63:0]            sqa_r, sqb_r, rad_r;
  logic signed [QW-1:0]   c9_r, c10_r;

  assign sqa_nxt = a8_r * a8_r;
  assign sqb_nxt = b8_r * b8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else begin
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    sqa_r <= sqa_nxt[63:0];
    sqb_r <= sqb_nxt[63:0];
    c9_r  <= c8_r;
    rad_r <= sqa_r + sqb_r;
    c10_r <= c9_r;
  end

  // Square root; c rides along as the tag.
  logic          isq_vld;
  logic [31:0]   isq_root;
  logic [QW-1:0] isq_tag;

  gcd_isqrt #(
    .TAG_W(QW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v10_r),
    .in_rad   (rad_r),
    .in_tag   (c10_r),
    .out_valid(isq_vld),
    .out_root (isq_root),
    .out_tag  (isq_tag)
  );

  // ---------------------------------------------------------------------------
  // Stage 11: atan2 set-up. With c negative, turn the vector by -90 degrees
  // and start the angle at a quarter turn.
  // ---------------------------------------------------------------------------
  logic                 v11_r;
  logic signed [QW-1:0] c_tag;
  logic signed [XW-1:0] c_ext, vec_x_nxt, vec_y_nxt, vec_x_r, vec_y_r;
  logic signed [ZW-1:0] vec_z_nxt, vec_z_r;

  assign c_tag = isq_tag;
  assign c_ext = XW'(c_tag);

  always_comb begin
    if (c_tag < 0) begin
      vec_x_nxt = XW'(isq_root);
      vec_y_nxt = -c_ext;
      vec_z_nxt = ZW'(gcd_pkg::QUARTER_TURN);
    end else begin
      vec_x_nxt = c_ext;
      vec_y_nxt = XW'(isq_root);
      vec_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else begin
      v11_r <= isq_vld;
    end
  end

  always_ff @(posedge clk) begin
    vec_x_r <= vec_x_nxt;
    vec_y_r <= vec_y_nxt;
    vec_z_r <= vec_z_nxt;
  end

  logic                 vec_vld;
  logic signed [ZW-1:0] vec_z;

  gcd_cordic #(
    .STAGES   (CORDIC_STAGES),
    .VECTORING(1'b1)
  ) u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v11_r),
    .in_x     (vec_x_r),
    .in_y     (vec_y_r),
    .in_z     (vec_z_r),
    .out_valid(vec_vld),
    .out_x    (),
    .out_y    (),
    .out_z    (vec_z)
  );

  // ---------------------------------------------------------------------------
  // Stage 12: clamp the central angle to [0, half turn].
  // Stage 13: scale by the circumference, drop 36 fraction bits.
  // ---------------------------------------------------------------------------
  logic        v12_r, v13_r;
  logic [31:0] ang_nxt, ang_r;
  logic [64:0] dist_prod;
  logic [27:0] dist_r;

  always_comb begin
    if (vec_z < 0) begin
      ang_nxt = '0;
    end else if (vec_z > ZW'(gcd_pkg::HALF_TURN)) begin
      ang_nxt = gcd_pkg::HALF_TURN;
    end else begin
      ang_nxt = vec_z[31:0];
    end
  end

  assign dist_prod = {33'd0, ang_r} * {32'd0, gcd_pkg::DIST_SCALE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
      v13_r <= 1'b0;
    end else begin
      v12_r <= vec_vld;
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    dist_r <= dist_prod[63:36];
  end

  assign out_valid       = v13_r;
  assign out_distance_dm = dist_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `GCD_ASSERT_IMPL(a_dist_saturated, out_valid, out_distance_dm <= gcd_pkg::DIST_MAX)
  `GCD_ASSERT_IMPL(a_fold_range, v4_r, rot_z_r[2] <= ZW'(QUARTER_S) && rot_z_r[2] >= -ZW'(QUARTER_S))
  `GCD_ASSERT_NEVER(a_vec_y_negative, v11_r && vec_y_r < 0)

endmodule

// ----- hw/rtl/gcd_cordic.sv -----
// Pipelined CORDIC, one registered micro-rotation per stage, rotation or vectoring mode.
module gcd_cordic #(
  parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF,
  parameter bit VECTORING = 1'b0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic signed [gcd_pkg::CORDIC_XW-1:0]   in_x,
  input  logic signed [gcd_pkg::CORDIC_XW-1:0]   in_y,
  input  logic signed [gcd_pkg::CORDIC_ZW-1:0]   in_z,
  output logic                                   out_valid,
  output logic signed [gcd_pkg::CORDIC_XW-1:0]   out_x,
  output logic signed [gcd_pkg::CORDIC_XW-1:0]   out_y,
  output logic signed [gcd_pkg::CORDIC_ZW-1:0]   out_z
);

  localparam int XW = gcd_pkg::CORDIC_XW;
  localparam int ZW = gcd_pkg::CORDIC_ZW;

  logic                 vld_r [STAGES];
  logic signed [XW-1:0] x_r   [STAGES];
  logic signed [XW-1:0] y_r   [STAGES];
  logic signed [ZW-1:0] z_r   [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_lut(i));
    logic                 v_i;
    logic signed [XW-1:0] x_i, y_i, x_sh, y_sh, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_i, z_nxt;
    logic                 rot_pos;

    if (i == 0) begin : g_first
      assign v_i = in_valid;
      assign x_i = in_x;
      assign y_i = in_y;
      assign z_i = in_z;
    end else begin : g_rest
      assign v_i = vld_r[i-1];
      assign x_i = x_r[i-1];
      assign y_i = y_r[i-1];
      assign z_i = z_r[i-1];
    end

    assign x_sh = x_i >>> i;
    assign y_sh = y_i >>> i;
    // turn counterclockwise when the residual angle says so (or y is not positive)
    assign rot_pos = VECTORING ? !(y_i > 0) : (z_i >= 0);

    always_comb begin
      if (rot_pos) begin
        x_nxt = x_i - y_sh;
        y_nxt = y_i + x_sh;
        z_nxt = z_i - ATAN;
      end else begin
        x_nxt = x_i + y_sh;
        y_nxt = y_i - x_sh;
        z_nxt = z_i + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i] <= x_nxt;
      y_r[i] <= y_nxt;
      z_r[i] <= z_nxt;
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_x     = x_r[STAGES-1];
  assign out_y     = y_r[STAGES-1];
  assign out_z     = z_r[STAGES-1];

endmodule

// ----- hw/rtl/gcd_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side tag.
module gcd_isqrt #(
  parameter int TAG_W = gcd_pkg::QW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [63:0]      in_rad,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int STEPS = gcd_pkg::ISQRT_STEPS;

  logic             vld_r [STEPS];
  logic [63:0]      rem_r [STEPS];
  logic [63:0]      root_r[STEPS];
  logic [TAG_W-1:0] tag_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic             v_i;
    logic [63:0]      rem_i, root_i, trial, rem_nxt, root_nxt;
    logic [TAG_W-1:0] tag_i;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_rad;
      assign root_i = 64'd0;
      assign tag_i  = in_tag;
    end else begin : g_rest
      assign v_i    = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign tag_i  = tag_r[k-1];
    end

    assign trial = root_i + BIT;

    always_comb begin
      if (rem_i >= trial) begin
        rem_nxt  = rem_i - trial;
        root_nxt = (root_i >> 1) + BIT;
      end else begin
        rem_nxt  = rem_i;
        root_nxt = root_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      tag_r[k]  <= tag_i;
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1][31:0];
  assign out_tag   = tag_r[STEPS-1];

endmodule
